### rtl/kes_pkg.sv
// shared types, constants and the arctangent table of the kepler solver
// no dependencies
`default_nettype none
package kes_pkg;

    localparam int ANGLE_FRAC_BITS = 28;
    localparam int CORDIC_STEPS    = 30;
    localparam int ANG_W           = 34;
    localparam int PROD_W          = 51;
    localparam int PROD_SHIFT      = 46 - ANGLE_FRAC_BITS;
    localparam int R_W             = 35;
    localparam int MAG_W           = 34;
    localparam int NUM_W           = MAG_W + ANGLE_FRAC_BITS;
    localparam int DEN_W           = 30;
    localparam int STEP_W          = 6;
    localparam int SUM_W           = 64;
    localparam int TOL_W           = 31;
    localparam int MAXIT_W         = 5;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 32;

    localparam logic signed [ANG_W-1:0] Q30_PI      = 34'sd3373259426;
    localparam logic signed [ANG_W-1:0] Q30_TWO_PI  = 34'sd6746518852;
    localparam logic signed [ANG_W-1:0] Q30_HALF_PI = 34'sd1686629713;
    localparam logic signed [ANG_W-1:0] Q30_GAIN    = 34'sd652032874;

    localparam logic [STEP_W-1:0] CORDIC_LAST = STEP_W'(CORDIC_STEPS - 1);
    localparam logic [STEP_W-1:0] DIV_LAST    = STEP_W'(NUM_W - 1);

    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 2'd1;

    typedef struct packed {
        logic signed [31:0] mean_anomaly;
        logic [15:0]        eccentricity;
    } kes_in_t;

    typedef struct packed {
        logic signed [31:0] eccentric_anomaly;
        logic               converged;
        logic [4:0]         iterations_used;
    } kes_out_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_REDUCE, ST_WRAP, ST_FOLD, ST_CORDIC,
        ST_MULT, ST_RESID, ST_DIV, ST_UPDATE, ST_FINISH
    } kes_state_t;

    typedef struct packed {
        logic              load;
        logic              reduce;
        logic              wrap;
        logic              fold;
        logic              cordic;
        logic              mult;
        logic              resid;
        logic              div;
        logic              update;
        logic              publish;
        logic [STEP_W-1:0] step;
    } kes_cmd_t;

    typedef struct packed {
        logic last_iter;
        logic out_free;
    } kes_status_t;

    // arctangent of 2^-i in q2.30
    function automatic logic signed [ANG_W-1:0] kes_atan(input logic [4:0] i);
        logic signed [ANG_W-1:0] v;
        case (i)
            5'd0:  v = 34'sh03243F6A8;
            5'd1:  v = 34'sh01DAC6705;
            5'd2:  v = 34'sh00FADBAFC;
            5'd3:  v = 34'sh007F56EA6;
            5'd4:  v = 34'sh003FEAB76;
            5'd5:  v = 34'sh001FFD55B;
            5'd6:  v = 34'sh000FFFAAA;
            5'd7:  v = 34'sh0007FFF55;
            5'd8:  v = 34'sh0003FFFEA;
            5'd9:  v = 34'sh0001FFFFD;
            5'd10: v = 34'sh0000FFFFF;
            5'd11: v = 34'sh00007FFFF;
            5'd12: v = 34'sh00003FFFF;
            5'd13: v = 34'sh00001FFFF;
            5'd14: v = 34'sh00000FFFF;
            5'd15: v = 34'sh000007FFF;
            5'd16: v = 34'sh000003FFF;
            5'd17: v = 34'sh000001FFF;
            5'd18: v = 34'sh000000FFF;
            5'd19: v = 34'sh0000007FF;
            5'd20: v = 34'sh0000003FF;
            5'd21: v = 34'sh0000001FF;
            5'd22: v = 34'sh0000000FF;
            5'd23: v = 34'sh00000007F;
            5'd24: v = 34'sh00000003F;
            5'd25: v = 34'sh00000001F;
            5'd26: v = 34'sh00000000F;
            5'd27: v = 34'sh000000008;
            5'd28: v = 34'sh000000004;
            5'd29: v = 34'sh000000002;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

### rtl/kes_ctrl.sv
// sequencer of the kepler solver: walks each newton iteration through its steps
// depends on kes_pkg
`default_nettype none
module kes_ctrl
    import kes_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  kes_status_t      status,
    output kes_cmd_t         cmd
);

    kes_state_t        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    // state and step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                cmd.reduce = 1'b1;
                state_next = ST_WRAP;
            end
            ST_WRAP: begin
                cmd.wrap   = 1'b1;
                state_next = ST_FOLD;
            end
            ST_FOLD: begin
                cmd.fold   = 1'b1;
                step_next  = '0;
                state_next = ST_CORDIC;
            end
            ST_CORDIC: begin
                cmd.cordic = 1'b1;
                if (step_reg == CORDIC_LAST) begin
                    step_next  = '0;
                    state_next = ST_MULT;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_MULT: begin
                cmd.mult   = 1'b1;
                state_next = ST_RESID;
            end
            ST_RESID: begin
                cmd.resid  = 1'b1;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div = 1'b1;
                if (step_reg == DIV_LAST) begin
                    step_next  = '0;
                    state_next = ST_UPDATE;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = status.last_iter ? ST_FINISH : ST_REDUCE;
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

### rtl/kes_datapath.sv
// datapath of the kepler solver: config registers, cordic, products,
// bit-serial divider, update and result register; depends on kes_pkg
`default_nettype none
module kes_datapath
    import kes_pkg::*;
#(
    parameter int ITERATION_LIMIT = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  kes_in_t                    s_data,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  kes_cmd_t                   cmd,
    output kes_status_t                status,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output kes_out_t                   m_data
);

    localparam int USED_W = $clog2(ITERATION_LIMIT + 1);

    logic [TOL_W-1:0]         tol_reg;
    logic [MAXIT_W-1:0]       maxit_reg;
    logic signed [31:0]       m_reg, e_reg, e_next;
    logic [15:0]              ecc_reg;
    logic [USED_W-1:0]        lim_reg, lim_next, used_reg;
    logic signed [ANG_W-1:0]  ang_reg, ang_next, x_reg, x_next, y_reg, y_next;
    logic                     flip_reg, flip_next;
    logic signed [PROD_W-1:0] sp_reg, cp_reg;
    logic                     rneg_reg, conv_reg;
    logic [DEN_W-1:0]         d_reg;
    logic [NUM_W-1:0]         num_reg, q_reg;
    logic [DEN_W-1:0]         rem_reg;
    kes_out_t                 out_reg;
    logic                     out_valid_reg;

    logic signed [ANG_W-1:0]  e4, xs, ys, at, c_val;
    logic signed [R_W-1:0]    es, ec, r_full, d_full;
    logic [MAG_W-1:0]         mag_next;
    logic [DEN_W-1:0]         d_next;
    logic [DEN_W:0]           rem_sh;
    logic signed [SUM_W-1:0]  e_ext, q_ext, sum;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg   <= TOL_W'(16);
            maxit_reg <= MAXIT_W'(16);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_TOLERANCE: tol_reg   <= cfg_data[TOL_W-1:0];
                REG_MAX_ITER:  maxit_reg <= cfg_data[MAXIT_W-1:0];
                default: ;
            endcase
        end
    end

    // effective iteration limit
    always_comb begin
        if (maxit_reg == '0)
            lim_next = USED_W'(1);
        else if (32'(maxit_reg) > ITERATION_LIMIT)
            lim_next = USED_W'(ITERATION_LIMIT);
        else
            lim_next = USED_W'(maxit_reg);
    end

    // angle reduction into [-pi/2, pi/2] and the residual angle of the cordic rotations
    always_comb begin
        e4        = {e_reg, 2'b00};
        ang_next  = ang_reg;
        flip_next = flip_reg;
        if (cmd.reduce) begin
            if (e4 >= Q30_TWO_PI)
                ang_next = e4 - Q30_TWO_PI;
            else if (e4 <= -Q30_TWO_PI)
                ang_next = e4 + Q30_TWO_PI;
            else
                ang_next = e4;
        end else if (cmd.wrap) begin
            if (ang_reg > Q30_PI)
                ang_next = ang_reg - Q30_TWO_PI;
            else if (ang_reg < -Q30_PI)
                ang_next = ang_reg + Q30_TWO_PI;
        end else if (cmd.fold) begin
            flip_next = 1'b0;
            if (ang_reg > Q30_HALF_PI) begin
                ang_next  = Q30_PI - ang_reg;
                flip_next = 1'b1;
            end else if (ang_reg < -Q30_HALF_PI) begin
                ang_next  = -Q30_PI - ang_reg;
                flip_next = 1'b1;
            end
        end else if (cmd.cordic) begin
            ang_next = ang_reg[ANG_W-1] ? ang_reg + at : ang_reg - at;
        end
    end

    // one cordic rotation per cycle
    always_comb begin
        xs     = x_reg >>> cmd.step[4:0];
        ys     = y_reg >>> cmd.step[4:0];
        at     = kes_atan(cmd.step[4:0]);
        x_next = x_reg;
        y_next = y_reg;
        if (cmd.fold) begin
            x_next = Q30_GAIN;
            y_next = '0;
        end else if (cmd.cordic) begin
            if (!ang_reg[ANG_W-1]) begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
            end else begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
            end
        end
    end

    // residual, derivative and magnitude
    always_comb begin
        c_val  = flip_reg ? -x_reg : x_reg;
        es     = R_W'(sp_reg >>> PROD_SHIFT);
        ec     = R_W'(cp_reg >>> PROD_SHIFT);
        r_full = R_W'(e_reg) - es - R_W'(m_reg);
        d_full = (R_W'(1) <<< ANGLE_FRAC_BITS) - ec;
        if (d_full <= 0)
            d_next = DEN_W'(1);
        else
            d_next = d_full[DEN_W-1:0];
        mag_next = r_full[R_W-1] ? MAG_W'(-r_full) : MAG_W'(r_full);
    end

    // restoring division step and newton update with saturation
    always_comb begin
        rem_sh = {rem_reg, num_reg[NUM_W-1]};
        e_ext  = SUM_W'(e_reg);
        q_ext  = $signed({{(SUM_W-NUM_W){1'b0}}, q_reg});
        sum    = rneg_reg ? e_ext + q_ext : e_ext - q_ext;
        if (sum > 64'sh7FFFFFFF)
            e_next = 32'sh7FFFFFFF;
        else if (sum < -64'sh80000000)
            e_next = 32'sh80000000;
        else
            e_next = sum[31:0];
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        ang_reg  <= ang_next;
        flip_reg <= flip_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        if (cmd.load) begin
            m_reg    <= s_data.mean_anomaly;
            e_reg    <= s_data.mean_anomaly;
            ecc_reg  <= s_data.eccentricity;
            lim_reg  <= lim_next;
            used_reg <= '0;
        end
        if (cmd.mult) begin
            sp_reg <= $signed({1'b0, ecc_reg}) * y_reg;
            cp_reg <= $signed({1'b0, ecc_reg}) * c_val;
        end
        if (cmd.resid) begin
            rneg_reg <= r_full[R_W-1];
            d_reg    <= d_next;
            conv_reg <= mag_next < MAG_W'(tol_reg);
            num_reg  <= {mag_next, {ANGLE_FRAC_BITS{1'b0}}};
            rem_reg  <= '0;
            q_reg    <= '0;
        end
        if (cmd.div) begin
            num_reg <= num_reg << 1;
            if (rem_sh >= {1'b0, d_reg}) begin
                rem_reg <= DEN_W'(rem_sh - {1'b0, d_reg});
                q_reg   <= {q_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh[DEN_W-1:0];
                q_reg   <= {q_reg[NUM_W-2:0], 1'b0};
            end
        end
        if (cmd.update) begin
            e_reg    <= e_next;
            used_reg <= used_reg + 1'b1;
        end
        if (cmd.publish) begin
            out_reg.eccentric_anomaly <= e_reg;
            out_reg.converged         <= conv_reg;
            out_reg.iterations_used   <= 5'(used_reg);
        end
    end

    // result register handshake
    always_ff @(posedge aclk) begin
        if (!aresetn)
            out_valid_reg <= 1'b0;
        else if (cmd.publish)
            out_valid_reg <= 1'b1;
        else if (m_ready)
            out_valid_reg <= 1'b0;
    end

    assign status  = '{last_iter: conv_reg || ((used_reg + 1'b1) == lim_reg),
                       out_free:  !out_valid_reg || m_ready};
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule
`default_nettype wire

### rtl/kepler_eccentric_anomaly_solver_top.sv
// kepler equation solver top level: newton iterations with cordic sin/cos
// and bit-serial division; depends on kes_pkg, kes_ctrl, kes_datapath
//
// usage
//   s_valid/s_ready/s_data carry one beat per item: mean anomaly (q4.28) and
//   eccentricity (q0.16). m_valid/m_ready/m_data return one beat per item:
//   eccentric anomaly, converged flag and iterations used.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write tolerance (index 0) and
//   max_iterations (index 1); cfg_ready is always high.
// sequencing
//   one item at a time. each newton iteration runs angle reduction (reduce,
//   wrap and fold), 30 cordic rotations, a product, a residual, 62 divider
//   steps (one quotient bit each) and an update. the next item can be taken
//   in the same cycle in which the result of the last one shows.
// reset and stalls
//   aresetn clears the sequencer, the result valid flag and restores the
//   register defaults. a finished result waits in the output register; the
//   next item is taken meanwhile, and its result waits until m_ready frees it.
`default_nettype none
module kepler_eccentric_anomaly_solver_top
    import kes_pkg::*;
#(
    parameter int ITERATION_LIMIT = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  kes_in_t                    s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output kes_out_t                   m_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    kes_cmd_t    cmd;
    kes_status_t status;

    assign cfg_ready = 1'b1;

    // sequencer
    kes_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // arithmetic
    kes_datapath #(
        .ITERATION_LIMIT (ITERATION_LIMIT)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
`default_nettype wire

### rtl/kes_checker.sv
// port-level checks on the kepler solver, bound to its top level
// depends on kes_pkg and kepler_eccentric_anomaly_solver_top
`default_nettype none
module kes_checker
    import kes_pkg::*;
(
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready,
    input kes_out_t  m_data
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // one item at a time: no input taken right after an accepted beat
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an item is in progress");

    // at least one iteration is always reported
    a_iter_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.iterations_used != 5'd0)
        else $error("zero iterations reported");

    // a result cannot appear the cycle after an input beat
    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result appeared too early");

endmodule

bind kepler_eccentric_anomaly_solver_top kes_checker u_kes_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire

### test/kepler_eccentric_anomaly_solver_top_tb.sv
// self-checking testbench for the kepler eccentric anomaly solver: random and directed
// items, a newton/cordic predictor in fixed point, register changes between phases
// depends on kes_pkg and kepler_eccentric_anomaly_solver_top
`default_nettype none
module kepler_eccentric_anomaly_solver_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import kes_pkg::*;

    localparam int  ITER_CAP    = 16;
    localparam int  FRAC        = 28;
    localparam int  SETTLE      = 2000;
    localparam longint CYCLE_LIMIT = 20_000_000;
    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint TWO_PI_Q30  = 64'sd6746518852;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint GAIN_Q30    = 64'sd652032874;

    // arctangent of 2^-i in q2.30
    localparam longint ATAN_Q30 [30] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
        64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002
    };

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    kes_in_t               s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    kes_out_t              m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    kes_in_t        pending_items [$];
    kes_out_t       expected_solutions [$];
    logic [30:0]    tol_reg;
    logic [4:0]     iter_reg;
    longint         cycle_cnt = 0;
    int             mismatches = 0;
    int             solutions_seen = 0;
    int             converged_seen = 0;

    kepler_eccentric_anomaly_solver_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // sin and cos of a q2.30 angle by 30 rotations
    function automatic void cordic_sin_cos(input longint ang, output longint s_out,
                                           output longint c_out);
        longint a, x, y, nx;
        logic   flip;
        a = ang % TWO_PI_Q30;
        x = GAIN_Q30;
        y = 0;
        flip = 1'b0;
        if (a > PI_Q30) a -= TWO_PI_Q30;
        else if (a < -PI_Q30) a += TWO_PI_Q30;
        if (a > HALF_PI_Q30) begin
            a = PI_Q30 - a;
            flip = 1'b1;
        end else if (a < -HALF_PI_Q30) begin
            a = -PI_Q30 - a;
            flip = 1'b1;
        end
        for (int i = 0; i < 30; i++) begin
            if (a >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                a -= ATAN_Q30[i];
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                a += ATAN_Q30[i];
            end
            x = nx;
        end
        s_out = y;
        c_out = flip ? -x : x;
    endfunction

    // newton iterations on e - ecc*sin(e) = m
    function automatic kes_out_t solve_kepler(input kes_in_t item, input logic [30:0] tol,
                                              input logic [4:0] iters);
        longint m, ecc, e, s, c, r, d;
        longint unsigned mag, q, rem;
        int     lim, used;
        logic   conv;
        kes_out_t res;
        m = longint'(item.mean_anomaly);
        ecc = longint'({1'b0, item.eccentricity});
        e = m;
        lim = (iters == 0) ? 1 : (iters > ITER_CAP ? ITER_CAP : int'(iters));
        used = 0;
        conv = 1'b0;
        while (used < lim && !conv) begin
            cordic_sin_cos(e * 4, s, c);
            r = e - ((ecc * s) >>> 18) - m;
            d = (longint'(1) << FRAC) - ((ecc * c) >>> 18);
            if (d <= 0) d = 1;
            mag = (r < 0) ? longint'(-r) : r;
            // bit-serial quotient with FRAC fraction bits
            q = mag / d;
            rem = mag % d;
            for (int i = 0; i < FRAC; i++) begin
                rem = rem << 1;
                q = q << 1;
                if (rem >= d) begin
                    rem -= d;
                    q |= 1;
                end
            end
            e = (r < 0) ? e + longint'(q) : e - longint'(q);
            if (e > 64'sh7FFFFFFF) e = 64'sh7FFFFFFF;
            if (e < -64'sh80000000) e = -64'sh80000000;
            used++;
            if (mag < longint'(tol)) conv = 1'b1;
        end
        res.eccentric_anomaly = e[31:0];
        res.converged = conv;
        res.iterations_used = used[4:0];
        return res;
    endfunction

    // no idling at all during every sixth stretch of the run
    function automatic logic idle_now();
        if ((cycle_cnt / 40000) % 6 == 2) return 1'b0;
        return $urandom_range(99) < 18;
    endfunction

    // register mirror follows accepted writes
    always @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg  <= 31'd16;
            iter_reg <= 5'd16;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_TOLERANCE: tol_reg  <= cfg_data[30:0];
                REG_MAX_ITER:  iter_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // input driver: predict on each accepted beat, then offer the next one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                expected_solutions.push_back(solve_kepler(s_data, tol_reg, iter_reg));
            if (!s_valid || s_ready) begin
                if (pending_items.size() > 0 && !idle_now()) begin
                    s_data  <= pending_items.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and back-pressure
    always @(posedge aclk) begin
        kes_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                solutions_seen++;
                if (m_data.converged) converged_seen++;
                if (expected_solutions.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: E=%0d conv=%0b iters=%0d",
                                 m_data.eccentric_anomaly, m_data.converged,
                                 m_data.iterations_used);
                end else begin
                    want = expected_solutions.pop_front();
                    if (want !== m_data) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected E=%0d conv=%0b iters=%0d, got E=%0d conv=%0b iters=%0d",
                                     want.eccentric_anomaly, want.converged,
                                     want.iterations_used, m_data.eccentric_anomaly,
                                     m_data.converged, m_data.iterations_used);
                    end
                end
            end
            m_ready <= !idle_now();
        end
    end

    // cycle limit
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || s_valid || expected_solutions.size() > 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic queue_item(input logic [31:0] m, input logic [15:0] ecc);
        kes_in_t it;
        it.mean_anomaly = m;
        it.eccentricity = ecc;
        pending_items.push_back(it);
    endtask

    // random items: half moderate angles, half full range
    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(3))
                0: queue_item($urandom, 16'($urandom));
                1: queue_item($urandom_range(32'h3FFFFFFF) - 32'h20000000,
                              16'($urandom_range(16'hFFFF)));
                2: queue_item($urandom_range(32'h1FFFFFFF) - 32'h10000000,
                              16'($urandom_range(16'h3FFF)));
                default: queue_item($urandom, 16'(16'hFFFF - $urandom_range(255)));
            endcase
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, quadrant edges, near-parabolic orbits, saturation
        queue_item(32'h0000_0000, 16'h0000);
        queue_item(32'h0000_0000, 16'hFFFF);
        queue_item(32'h7FFF_FFFF, 16'h0000);
        queue_item(32'h7FFF_FFFF, 16'hFFFF);
        queue_item(32'h8000_0000, 16'hFFFF);
        queue_item(32'h8000_0000, 16'h8000);
        queue_item(32'h3243_F6A9, 16'hFFFF);
        queue_item(32'hCDBC_0957, 16'hFFFF);
        queue_item(32'h1921_FB54, 16'h8000);
        queue_item(32'hE6DE_04AC, 16'h4000);
        queue_item(32'h0000_0001, 16'hFFFF);
        queue_item(32'hFFFF_FFFF, 16'hFFFF);
        queue_item(32'h6487_ED51, 16'hC000);
        queue_item(32'h4000_0000, 16'h0001);
        queue_item(32'h1000_0000, 16'hAAAA);
        queue_item(32'hF000_0000, 16'h5555);
        drain();

        // zero tolerance: never converges
        write_reg(REG_TOLERANCE, 32'h0000_0000);
        queue_item(32'h1000_0000, 16'h8000);
        queue_item(32'h8000_0000, 16'hFFFF);
        queue_random(80);
        drain();

        // widest tolerance with single iteration
        write_reg(REG_TOLERANCE, 32'hFFFF_FFFF);
        write_reg(REG_MAX_ITER, 32'h0000_0001);
        queue_random(90);
        drain();

        // iteration register zero acts as one
        write_reg(REG_MAX_ITER, 32'hFFFF_FFE0);
        write_reg(REG_TOLERANCE, 32'h0000_4000);
        queue_random(80);
        drain();

        // iteration register above the cap, unused index ignored
        write_reg(REG_MAX_ITER, 32'h0000_001F);
        write_reg(2'd3, $urandom);
        write_reg(REG_TOLERANCE, $urandom_range(255));
        queue_random(100);
        drain();

        // random settings
        for (int p = 0; p < 3; p++) begin
            write_reg(REG_TOLERANCE, $urandom & 32'h8000_FFFF);
            write_reg(REG_MAX_ITER, $urandom);
            queue_random(60);
            drain();
        end

        $display("%0d results checked, %0d converged, over eight register settings",
                 solutions_seen, converged_seen);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire
